@@ hw/rtl/bte_pkg.sv @@
// Shared types, constants and tables for the bonded term energy block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bte_pkg;

   localparam logic [1:0] OP_BOND     = 2'd0;
   localparam logic [1:0] OP_ANGLE    = 2'd1;
   localparam logic [1:0] OP_DIHEDRAL = 2'd2;
   localparam logic [1:0] OP_IMPROPER = 2'd3;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int QUEUE_DEPTH      = 4;

   // degrees in Q16.16
   localparam logic signed [33:0] DEG_FULL    = 34'sd23592960;
   localparam logic signed [33:0] DEG_HALF    = 34'sd11796480;
   localparam logic signed [33:0] DEG_QUARTER = 34'sd5898240;

   // multiple of a full turn that makes any 35-bit angle positive
   localparam logic [36:0] RED_OFFSET = 37'd96636764160;
   // floor(2^24 / 45); a full turn is 45 * 2^19
   localparam logic [18:0] RECIP45    = 19'd372827;
   localparam logic [5:0]  TURN_DIV   = 6'd45;

   localparam logic [40:0]        DEG2RAD_Q46 = 41'd1228166294537;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic [1:0]         op;
      logic               fneg;
      logic [31:0]        fmag;
      logic signed [17:0] pd;
      logic [127:0]       sq;
      logic [31:0]        z0;
      logic               flip0;
      logic [31:0]        z1;
      logic               flip1;
   } bte_item_type;

   function automatic logic signed [32:0] cordic_atan(input logic [4:0] idx);
      logic signed [32:0] v;
      case (idx)
         5'd0:  v = 33'sd843314857;
         5'd1:  v = 33'sd497837829;
         5'd2:  v = 33'sd263043837;
         5'd3:  v = 33'sd133525159;
         5'd4:  v = 33'sd67021687;
         5'd5:  v = 33'sd33543516;
         5'd6:  v = 33'sd16775851;
         5'd7:  v = 33'sd8388437;
         5'd8:  v = 33'sd4194283;
         5'd9:  v = 33'sd2097149;
         5'd10: v = 33'sd1048576;
         5'd11: v = 33'sd524288;
         5'd12: v = 33'sd262144;
         5'd13: v = 33'sd131072;
         5'd14: v = 33'sd65536;
         5'd15: v = 33'sd32768;
         5'd16: v = 33'sd16384;
         5'd17: v = 33'sd8192;
         5'd18: v = 33'sd4096;
         5'd19: v = 33'sd2048;
         5'd20: v = 33'sd1024;
         5'd21: v = 33'sd512;
         5'd22: v = 33'sd256;
         5'd23: v = 33'sd128;
         5'd24: v = 33'sd64;
         5'd25: v = 33'sd32;
         5'd26: v = 33'sd16;
         5'd27: v = 33'sd8;
         5'd28: v = 33'sd4;
         5'd29: v = 33'sd2;
         5'd30: v = 33'sd1;
         default: v = 33'sd0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/bonded_term_energy.sv @@
// Bonded term energy evaluator. One request per clock is accepted while busy
// is low; each request yields exactly one result, strobed by rsp_valid for a
// single cycle once the request has passed 7 front stages, 1 queue hop,
// CORDIC_STEPS rotation stages and 7 product and rounding stages (the result
// is taken at the edge that ends the strobe).
// The result path has no back-pressure, so the queue drains every cycle and
// busy stays low in normal operation. Depends on bte_pkg and all bte_ modules.
`timescale 1ns / 1ps

module bonded_term_energy #(
   parameter int CORDIC_STEPS = bte_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_measured_value,
   input  logic signed [31:0] req_ref_value,
   input  logic signed [17:0] req_phase_cos,
   input  logic [2:0]         req_multiplicity,
   input  logic signed [31:0] req_force_const,
   output logic               rsp_valid,
   output logic signed [47:0] rsp_energy,
   output logic               rsp_saturated
);

   localparam int BACK_LAT = CORDIC_STEPS + 7;

   logic                  f_valid;
   bte_pkg::bte_item_type f_item;
   logic                  q_full, q_push, q_valid;
   bte_pkg::bte_item_type q_item;

   assign busy   = q_full;
   assign q_push = f_valid && !q_full;

   bte_front u_front (
      .clock(clock), .reset(reset), .en(!q_full), .start(start),
      .req_opcode(req_opcode), .req_measured_value(req_measured_value),
      .req_ref_value(req_ref_value), .req_phase_cos(req_phase_cos),
      .req_multiplicity(req_multiplicity), .req_force_const(req_force_const),
      .out_valid(f_valid), .out_item(f_item));

   bte_fifo u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_item(f_item),
      .pop(q_valid), .head_valid(q_valid), .head_item(q_item), .full(q_full));

   bte_back #(.STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_item(q_item),
      .rsp_valid(rsp_valid), .rsp_energy(rsp_energy), .rsp_saturated(rsp_saturated));

   // evaluator drains one request per cycle, so the queue never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue filled up");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(f_valid && q_full && !$past(q_full)) || !q_push)
      else $error("push into full queue");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> ##(BACK_LAT) rsp_valid)
      else $error("request lost in evaluator");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(q_valid, BACK_LAT))
      else $error("result without request");

endmodule

@@ hw/rtl/bte_angred.sv @@
// Angle reduction: Q16.16 degrees to first-quadrant Q2.30 radians plus fold flag.
// Five register stages, all advanced by en. Uses bte_pkg.
`timescale 1ns / 1ps

module bte_angred (
   input  logic               clock,
   input  logic               en,
   input  logic signed [34:0] arg,
   output logic [31:0]        z,
   output logic               flip
);

   logic [36:0]        u;
   logic [36:0]        qprod;
   logic [17:0]        x_ff;
   logic [18:0]        low_ff;
   logic [12:0]        q_ff;
   logic [18:0]        rx;
   logic [6:0]         rx_c;
   logic [24:0]        r0_ff;
   logic signed [33:0] r_s;
   logic signed [33:0] r_f;
   logic               flip_in;
   logic [33:0]        a_w;
   logic [22:0]        a_ff;
   logic               flip3_ff;
   logic [43:0]        phi_ff;
   logic [42:0]        plo_ff;
   logic               flip4_ff;
   logic [63:0]        zsum;
   logic [31:0]        z_ff;
   logic               flip5_ff;

   always_comb begin
      u     = 37'(arg) + bte_pkg::RED_OFFSET;
      qprod = u[36:19] * bte_pkg::RECIP45;
   end

   // remainder of the coarse quotient is below twice the divisor
   always_comb begin
      rx   = {1'b0, x_ff} - 19'(q_ff) * 19'(bte_pkg::TURN_DIV);
      rx_c = (rx[6:0] >= 7'(bte_pkg::TURN_DIV)) ? rx[6:0] - 7'(bte_pkg::TURN_DIV) : rx[6:0];
   end

   always_comb begin
      r_s = $signed({9'b0, r0_ff});
      if (r_s >= bte_pkg::DEG_HALF) begin
         r_s = r_s - bte_pkg::DEG_FULL;
      end
      flip_in = 1'b0;
      r_f     = r_s;
      if (r_s > bte_pkg::DEG_QUARTER) begin
         r_f     = bte_pkg::DEG_HALF - r_s;
         flip_in = 1'b1;
      end else if (r_s < -bte_pkg::DEG_QUARTER) begin
         r_f     = -bte_pkg::DEG_HALF - r_s;
         flip_in = 1'b1;
      end
      a_w = r_f[33] ? 34'(-r_f) : 34'(r_f);
   end

   always_comb begin
      zsum = {phi_ff, 20'd0} + 64'(plo_ff) + 64'h0000_0000_8000_0000;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= u[36:19];
         low_ff   <= u[18:0];
         q_ff     <= qprod[36:24];
         r0_ff    <= {rx_c[5:0], low_ff};
         a_ff     <= a_w[22:0];
         flip3_ff <= flip_in;
         phi_ff   <= a_ff * bte_pkg::DEG2RAD_Q46[40:20];
         plo_ff   <= a_ff * bte_pkg::DEG2RAD_Q46[19:0];
         flip4_ff <= flip3_ff;
         z_ff     <= zsum[63:32];
         flip5_ff <= flip4_ff;
      end
   end

   assign z    = z_ff;
   assign flip = flip5_ff;

endmodule

@@ hw/rtl/bte_front.sv @@
// Front end: request capture, term classification, bond/improper squares and
// the two angle reductions. Seven stages that all stall on en. Uses bte_pkg, bte_angred.
`timescale 1ns / 1ps

module bte_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  start,
   input  logic [1:0]            req_opcode,
   input  logic signed [31:0]    req_measured_value,
   input  logic signed [31:0]    req_ref_value,
   input  logic signed [17:0]    req_phase_cos,
   input  logic [2:0]            req_multiplicity,
   input  logic signed [31:0]    req_force_const,
   output logic                  out_valid,
   output bte_pkg::bte_item_type out_item
);

   typedef struct packed {
      logic [1:0]         op;
      logic               fneg;
      logic [31:0]        fmag;
      logic signed [17:0] pd;
   } meta_type;

   logic               vld_ff [1:7];
   logic [1:0]         op1_ff, op2_ff;
   logic signed [31:0] v1_ff, r1_ff, fc1_ff, fc2_ff;
   logic signed [17:0] pd1_ff, pd2_ff;
   logic [2:0]         n1_ff;

   logic signed [35:0] nv;
   logic signed [34:0] arg0_in;
   logic signed [32:0] vw;
   logic signed [34:0] arg0_ff, arg1_ff;
   logic signed [63:0] vsq_ff, rsq_ff;
   logic signed [33:0] dimp_ff;

   logic signed [63:0] dbond;
   logic [63:0]        dmag_in;
   logic [63:0]        dmag_ff;
   meta_type           meta_in;
   meta_type           meta_ff [3:7];
   logic [63:0]        p00_ff, p01_ff, p11_ff;
   logic [127:0]       sq5_ff, sq6_ff, sq7_ff;
   logic [31:0]        z0, z1;
   logic               flip0, flip1;

   always_comb begin
      nv      = $signed({1'b0, n1_ff}) * v1_ff;
      arg0_in = (op1_ff == bte_pkg::OP_DIHEDRAL) ? nv[34:0] : 35'(v1_ff);
      vw      = (34'(v1_ff) > bte_pkg::DEG_HALF) ? 33'(34'(v1_ff) - bte_pkg::DEG_FULL)
                                                 : 33'(v1_ff);
   end

   always_comb begin
      dbond   = vsq_ff - rsq_ff;
      if (op2_ff == bte_pkg::OP_BOND) begin
         dmag_in = dbond[63] ? 64'(-dbond) : 64'(dbond);
      end else begin
         dmag_in = dimp_ff[33] ? 64'(34'(-dimp_ff)) : 64'(34'(dimp_ff));
      end
      meta_in.op   = op2_ff;
      meta_in.fneg = fc2_ff[31];
      meta_in.fmag = fc2_ff[31] ? 32'(-fc2_ff) : 32'(fc2_ff);
      meta_in.pd   = pd2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 7; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[1] <= start;
         for (int k = 2; k <= 7; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff  <= req_opcode;
         v1_ff   <= req_measured_value;
         r1_ff   <= req_ref_value;
         pd1_ff  <= req_phase_cos;
         n1_ff   <= req_multiplicity;
         fc1_ff  <= req_force_const;

         op2_ff  <= op1_ff;
         pd2_ff  <= pd1_ff;
         fc2_ff  <= fc1_ff;
         arg0_ff <= arg0_in;
         arg1_ff <= 35'(r1_ff);
         vsq_ff  <= v1_ff * v1_ff;
         rsq_ff  <= r1_ff * r1_ff;
         dimp_ff <= 34'(vw) - 34'(r1_ff);

         dmag_ff    <= dmag_in;
         meta_ff[3] <= meta_in;
         for (int k = 4; k <= 7; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end

         p00_ff <= dmag_ff[31:0] * dmag_ff[31:0];
         p01_ff <= dmag_ff[31:0] * dmag_ff[63:32];
         p11_ff <= dmag_ff[63:32] * dmag_ff[63:32];
         sq5_ff <= 128'(p00_ff) + (128'(p01_ff) << 33) + (128'(p11_ff) << 64);
         sq6_ff <= sq5_ff;
         sq7_ff <= sq6_ff;
      end
   end

   bte_angred u_red0 (.clock(clock), .en(en), .arg(arg0_ff), .z(z0), .flip(flip0));
   bte_angred u_red1 (.clock(clock), .en(en), .arg(arg1_ff), .z(z1), .flip(flip1));

   always_comb begin
      out_item.op    = meta_ff[7].op;
      out_item.fneg  = meta_ff[7].fneg;
      out_item.fmag  = meta_ff[7].fmag;
      out_item.pd    = meta_ff[7].pd;
      out_item.sq    = sq7_ff;
      out_item.z0    = z0;
      out_item.flip0 = flip0;
      out_item.z1    = z1;
      out_item.flip1 = flip1;
   end

   assign out_valid = vld_ff[7];

endmodule

@@ hw/rtl/bte_fifo.sv @@
// Short queue of classified terms between front end and evaluator.
// Register array with read and write pointers. Uses bte_pkg.
`timescale 1ns / 1ps

module bte_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bte_pkg::bte_item_type push_item,
   input  logic                  pop,
   output logic                  head_valid,
   output bte_pkg::bte_item_type head_item,
   output logic                  full
);

   localparam int PW = $clog2(bte_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(bte_pkg::QUEUE_DEPTH + 1);

   bte_pkg::bte_item_type mem_ff [bte_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;
   logic          do_pop;

   assign do_pop     = pop && (cnt_ff != '0);
   assign head_valid = (cnt_ff != '0);
   assign head_item  = mem_ff[rd_ff];
   assign full       = (cnt_ff == CW'(bte_pkg::QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(bte_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(bte_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CW'(push) - CW'(do_pop);
      end
   end

endmodule

@@ hw/rtl/bte_cordic.sv @@
// Pipelined rotation CORDIC: one register stage per iteration, x out in Q2.30.
// Uses bte_pkg for the gain and the arctangent table.
`timescale 1ns / 1ps

module bte_cordic #(
   parameter int STEPS = bte_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic signed [32:0] z_in,
   output logic signed [33:0] x_out
);

   logic signed [33:0] x_ff [STEPS];
   logic signed [33:0] y_ff [STEPS];
   logic signed [32:0] z_ff [STEPS];
   logic signed [33:0] xin [STEPS];
   logic signed [33:0] yin [STEPS];
   logic signed [32:0] zin [STEPS];

   always_comb begin
      xin[0] = bte_pkg::CORDIC_GAIN;
      yin[0] = '0;
      zin[0] = z_in;
      for (int i = 1; i < STEPS; i++) begin
         xin[i] = x_ff[i-1];
         yin[i] = y_ff[i-1];
         zin[i] = z_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STEPS; i++) begin
         if (!zin[i][32]) begin
            x_ff[i] <= xin[i] - (yin[i] >>> i);
            y_ff[i] <= yin[i] + (xin[i] >>> i);
            z_ff[i] <= zin[i] - bte_pkg::cordic_atan(5'(i));
         end else begin
            x_ff[i] <= xin[i] + (yin[i] >>> i);
            y_ff[i] <= yin[i] - (xin[i] >>> i);
            z_ff[i] <= zin[i] + bte_pkg::cordic_atan(5'(i));
         end
      end
   end

   assign x_out = x_ff[STEPS-1];

endmodule

@@ hw/rtl/bte_back.sv @@
// Evaluator: two cosine pipelines, then the angle square or dihedral term, force
// constant product, rounding and saturation. Never stalls. Uses bte_pkg, bte_cordic.
`timescale 1ns / 1ps

module bte_back #(
   parameter int STEPS = bte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  bte_pkg::bte_item_type in_item,
   output logic                  rsp_valid,
   output logic signed [47:0]    rsp_energy,
   output logic                  rsp_saturated
);

   bte_pkg::bte_item_type side_ff [STEPS];
   logic                  sv_ff [STEPS];
   logic signed [33:0]    x0, x1;

   bte_pkg::bte_item_type b1_item_ff, b2_item_ff;
   logic                  b1_ff, b2_ff, b3_ff, b4_ff, b5_ff, b6_ff, out_ff;
   logic signed [33:0]    c0_ff, c1_ff;
   logic signed [34:0]    dang;
   logic signed [51:0]    pdc;
   logic signed [52:0]    tw;
   logic [34:0]           angmag_ff;
   logic [52:0]           tmag_ff;
   logic                  tneg_ff;
   logic [69:0]           angsq;
   logic [127:0]          m_in, m_ff;
   logic                  neg_in;
   logic                  neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [1:0]            op3_ff, op4_ff, op5_ff, op6_ff;
   logic [31:0]           fmag3_ff;
   logic [63:0]           pp_ff [4];
   logic [159:0]          p_ff;
   logic [160:0]          rnd;
   logic [160:0]          pr_ff;
   logic [160:0]          shifted;
   logic [47:0]           lim, mag;
   logic                  sat;
   logic signed [47:0]    energy_ff;
   logic                  sat_ff;

   bte_cordic #(.STEPS(STEPS)) u_cos0 (
      .clock(clock), .z_in($signed({1'b0, in_item.z0})), .x_out(x0));
   bte_cordic #(.STEPS(STEPS)) u_cos1 (
      .clock(clock), .z_in($signed({1'b0, in_item.z1})), .x_out(x1));

   // side data rides along with the rotations
   always_ff @(posedge clock) begin
      side_ff[0] <= in_item;
      for (int k = 1; k < STEPS; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STEPS; k++) begin
            sv_ff[k] <= 1'b0;
         end
         b1_ff  <= 1'b0;
         b2_ff  <= 1'b0;
         b3_ff  <= 1'b0;
         b4_ff  <= 1'b0;
         b5_ff  <= 1'b0;
         b6_ff  <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         sv_ff[0] <= in_valid;
         for (int k = 1; k < STEPS; k++) begin
            sv_ff[k] <= sv_ff[k-1];
         end
         b1_ff  <= sv_ff[STEPS-1];
         b2_ff  <= b1_ff;
         b3_ff  <= b2_ff;
         b4_ff  <= b3_ff;
         b5_ff  <= b4_ff;
         b6_ff  <= b5_ff;
         out_ff <= b6_ff;
      end
   end

   always_comb begin
      dang = 35'(c0_ff) - 35'(c1_ff);
      pdc  = b1_item_ff.pd * c0_ff;
      tw   = (53'sd1 <<< 46) + 53'(pdc);
   end

   always_comb begin
      angsq  = angmag_ff * angmag_ff;
      neg_in = b2_item_ff.fneg;
      case (b2_item_ff.op)
         bte_pkg::OP_ANGLE: m_in = 128'(angsq);
         bte_pkg::OP_DIHEDRAL: begin
            m_in   = 128'(tmag_ff);
            neg_in = b2_item_ff.fneg ^ tneg_ff;
         end
         default: m_in = b2_item_ff.sq;
      endcase
   end

   always_comb begin
      case (op5_ff)
         bte_pkg::OP_BOND:     rnd = 161'(1) << 65;
         bte_pkg::OP_ANGLE:    rnd = 161'(1) << 60;
         bte_pkg::OP_DIHEDRAL: rnd = 161'(1) << 45;
         default:              rnd = 161'(1) << 32;
      endcase
   end

   always_comb begin
      case (op6_ff)
         bte_pkg::OP_BOND:     shifted = pr_ff >> 66;
         bte_pkg::OP_ANGLE:    shifted = pr_ff >> 61;
         bte_pkg::OP_DIHEDRAL: shifted = pr_ff >> 46;
         default:              shifted = pr_ff >> 33;
      endcase
      lim = neg6_ff ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      sat = shifted > 161'(lim);
      mag = sat ? lim : shifted[47:0];
   end

   always_ff @(posedge clock) begin
      b1_item_ff <= side_ff[STEPS-1];
      c0_ff      <= side_ff[STEPS-1].flip0 ? -x0 : x0;
      c1_ff      <= side_ff[STEPS-1].flip1 ? -x1 : x1;

      b2_item_ff <= b1_item_ff;
      angmag_ff  <= dang[34] ? 35'(-dang) : 35'(dang);
      tneg_ff    <= tw[52];
      tmag_ff    <= tw[52] ? 53'(-tw) : 53'(tw);

      m_ff     <= m_in;
      neg3_ff  <= neg_in;
      op3_ff   <= b2_item_ff.op;
      fmag3_ff <= b2_item_ff.fmag;

      for (int k = 0; k < 4; k++) begin
         pp_ff[k] <= fmag3_ff * m_ff[32*k +: 32];
      end
      neg4_ff <= neg3_ff;
      op4_ff  <= op3_ff;

      p_ff    <= 160'(pp_ff[0]) + (160'(pp_ff[1]) << 32) + (160'(pp_ff[2]) << 64)
                 + (160'(pp_ff[3]) << 96);
      neg5_ff <= neg4_ff;
      op5_ff  <= op4_ff;

      pr_ff   <= 161'(p_ff) + rnd;
      neg6_ff <= neg5_ff;
      op6_ff  <= op5_ff;

      energy_ff <= neg6_ff ? $signed(~mag + 48'd1) : $signed(mag);
      sat_ff    <= sat;
   end

   assign rsp_valid     = out_ff;
   assign rsp_energy    = energy_ff;
   assign rsp_saturated = sat_ff;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for bonded_term_energy: directed table plus random
// requests, checked against an in-bench energy predictor. Depends on bte_pkg.
`timescale 1ns / 1ps

module testbench;

   localparam logic [1:0] OP_BOND     = bte_pkg::OP_BOND;
   localparam logic [1:0] OP_ANGLE    = bte_pkg::OP_ANGLE;
   localparam logic [1:0] OP_DIHEDRAL = bte_pkg::OP_DIHEDRAL;
   localparam logic [1:0] OP_IMPROPER = bte_pkg::OP_IMPROPER;

   localparam int  ANGLE_STEPS  = bte_pkg::CORDIC_STEPS_DEF;
   localparam int  RANDOM_COUNT = 1930;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  DRAIN_CYCLES = 64;
   localparam longint TURN      = 64'sd23592960;
   localparam longint HALF_TURN = 64'sd11796480;
   localparam longint QTR_TURN  = 64'sd5898240;
   localparam logic [63:0] RAD_PER_DEG = 64'd1228166294537;
   localparam longint ROT_GAIN  = 64'sd652032874;
   localparam logic [47:0] E_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] E_MIN = 48'h8000_0000_0000;

   localparam longint ARCTAN [32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   typedef struct {
      logic [47:0] energy;
      logic        saturated;
   } energy_type;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] value;
      logic signed [31:0] refv;
      logic signed [17:0] pd;
      logic [2:0]         mult;
      logic signed [31:0] fc;
      bit                 known;
      logic [47:0]        energy;
      logic               saturated;
   } term_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic signed [31:0] req_measured_value;
   logic signed [31:0] req_ref_value;
   logic signed [17:0] req_phase_cos;
   logic [2:0]         req_multiplicity;
   logic signed [31:0] req_force_const;
   logic               rsp_valid;
   logic signed [47:0] rsp_energy;
   logic               rsp_saturated;

   energy_type pending_energy[$];
   int         error_count = 0;
   int         cycle_count = 0;

   bonded_term_energy i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_measured_value(req_measured_value),
      .req_ref_value(req_ref_value), .req_phase_cos(req_phase_cos),
      .req_multiplicity(req_multiplicity), .req_force_const(req_force_const),
      .rsp_valid(rsp_valid), .rsp_energy(rsp_energy), .rsp_saturated(rsp_saturated)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // cosine of a Q16.16 degree angle, Q2.30
   function automatic longint cosine_q30(input longint deg);
      longint      r, x, y, z, dx, dy;
      logic [63:0] a;
      bit          flip;
      r = deg % TURN;
      flip = 1'b0;
      if (r < 0) r += TURN;
      if (r >= HALF_TURN) r -= TURN;
      if (r > QTR_TURN) begin
         r = HALF_TURN - r;
         flip = 1'b1;
      end else if (r < -QTR_TURN) begin
         r = -HALF_TURN - r;
         flip = 1'b1;
      end
      a = (r < 0) ? -r : r;
      z = longint'((a * RAD_PER_DEG + 64'h8000_0000) >> 32);
      x = ROT_GAIN;
      y = 0;
      for (int i = 0; i < ANGLE_STEPS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN[i];
         end
      end
      return flip ? -x : x;
   endfunction

   // sign * round_half_away(fmag * sq / 2^shift), clipped to 48 bits
   function automatic energy_type scale_clip(input logic [31:0] fmag, input bit neg,
                                             input logic [127:0] sq, input int shift);
      logic [255:0] p;
      logic [63:0]  mag, lim;
      energy_type   res;
      p = 256'(fmag) * 256'(sq);
      p = p + (256'd1 << (shift - 1));
      p = p >> shift;
      mag = p[63:0];
      lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      res.saturated = 1'b0;
      if ((|p[255:64]) || mag > lim) begin
         mag = lim;
         res.saturated = 1'b1;
      end
      res.energy = neg ? 48'(-mag) : mag[47:0];
      return res;
   endfunction

   function automatic logic [127:0] square_mag(input longint d);
      logic [63:0] m;
      m = (d < 0) ? -d : d;
      return 128'(m) * 128'(m);
   endfunction

   function automatic energy_type term_energy(input logic [1:0] op,
         input logic signed [31:0] value, input logic signed [31:0] refv,
         input logic signed [17:0] pd, input logic [2:0] mult,
         input logic signed [31:0] fc);
      longint      v, r, p, n, d;
      logic [31:0] fmag;
      bit          fneg;
      energy_type  res;
      v = value;
      r = refv;
      p = pd;
      n = mult;
      fneg = fc < 0;
      fmag = fneg ? -fc : fc;
      case (op)
         OP_BOND:  res = scale_clip(fmag, fneg, square_mag(v * v - r * r), 66);
         OP_ANGLE: res = scale_clip(fmag, fneg,
                                    square_mag(cosine_q30(v) - cosine_q30(r)), 61);
         OP_DIHEDRAL: begin
            d = (64'sd1 <<< 46) + p * cosine_q30(n * v);
            res = scale_clip(fmag, fneg != (d < 0), 128'((d < 0) ? -d : d), 46);
         end
         default: begin
            if (v > HALF_TURN) v -= TURN;
            res = scale_clip(fmag, fneg, square_mag(v - r), 33);
         end
      endcase
      return res;
   endfunction

   task automatic send_term(input term_row_type t);
      energy_type e;
      req_opcode         <= t.op;
      req_measured_value <= t.value;
      req_ref_value      <= t.refv;
      req_phase_cos      <= t.pd;
      req_multiplicity   <= t.mult;
      req_force_const    <= t.fc;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
      if (t.known) begin
         e.energy = t.energy;
         e.saturated = t.saturated;
      end else begin
         e = term_energy(t.op, t.value, t.refv, t.pd, t.mult, t.fc);
      end
      pending_energy.insert(pending_energy.size(), e);
   endtask

   task automatic idle_gap(input bit quiet);
      int g, k;
      k = $urandom_range(0, 99);
      if (quiet || k < 50) g = 0;
      else if (k < 92) g = $urandom_range(1, 3);
      else g = $urandom_range(10, 40);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] spread(input int unsigned range);
      return $signed($urandom_range(0, 2 * range)) - $signed(range);
   endfunction

   function automatic term_row_type random_term();
      term_row_type t;
      bit           wild;
      wild = ($urandom_range(0, 9) < 2);
      t.op = 2'($urandom_range(0, 3));
      t.known = 1'b0;
      t.pd = $urandom_range(0, 3) == 0 ? 18'($urandom) :
             ($urandom_range(0, 1) ? 18'sd65536 : -18'sd65536);
      t.mult = 3'($urandom_range(0, 7));
      t.fc = wild ? $urandom : spread(32'h3FFF_FFFF);
      if (wild) begin
         t.value = $urandom;
         t.refv = $urandom;
      end else if (t.op == OP_BOND) begin
         t.value = $urandom_range(0, 32'h3_0000);
         t.refv = $urandom_range(0, 32'h3_0000);
      end else begin
         t.value = spread(32'd400 << 16);
         t.refv = spread(32'd200 << 16);
      end
      return t;
   endfunction

   always @(posedge clock) begin
      energy_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_energy.size() == 0) begin
            $error("unexpected result: energy %h", rsp_energy);
            error_count++;
         end else begin
            e = pending_energy.pop_front();
            if (rsp_energy !== e.energy) begin
               $error("energy: expected %h, actual %h", e.energy, rsp_energy);
               error_count++;
            end
            if (rsp_saturated !== e.saturated) begin
               $error("saturated: expected %b, actual %b", e.saturated, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bonded_term_energy regression: fail");
         $finish;
      end
   end

   term_row_type directed [] = '{
      '{OP_BOND, 32'sh1_0000, 32'sh8000, 18'sd0, 3'd0, 32'sd0, 1, 48'd0, 1'b0},
      '{OP_BOND, 32'sh1_0000, 32'sh1_0000, 18'sd0, 3'd0, 32'sh7FFF_FFFF, 1, 48'd0, 1'b0},
      '{OP_BOND, 32'sh7FFF_FFFF, 32'sd0, 18'sd0, 3'd0, 32'sh7FFF_FFFF, 1, E_MAX, 1'b1},
      '{OP_BOND, 32'sh8000_0000, 32'sd0, 18'sd0, 3'd0, 32'sh8000_0000, 1, E_MIN, 1'b1},
      '{OP_BOND, 32'sh1_8000, 32'sh1_0000, 18'sd0, 3'd0, 32'sh64_0000, 0, 48'd0, 1'b0},
      '{OP_ANGLE, 32'sh3C_0000, 32'sh3C_0000, 18'sd0, 3'd0, 32'sh64_0000, 1, 48'd0, 1'b0},
      '{OP_ANGLE, 32'sh8000_0000, 32'sh7FFF_FFFF, 18'sd0, 3'd0, 32'sh7FFF_FFFF, 0, 48'd0, 1'b0},
      '{OP_ANGLE, 32'sd0, 32'shB4_0000, 18'sd0, 3'd0, 32'sh8000_0000, 0, 48'd0, 1'b0},
      '{OP_ANGLE, 32'shFFA6_0000, 32'sh10E_0000, 18'sd0, 3'd0, 32'sh1_0000, 0, 48'd0, 1'b0},
      '{OP_DIHEDRAL, 32'sh2D_0000, 32'sd0, 18'sd65536, 3'd0, 32'sh1_0000, 0, 48'd0, 1'b0},
      '{OP_DIHEDRAL, 32'sh2D_0000, 32'sd0, 18'sd65536, 3'd7, 32'sh1_0000, 0, 48'd0, 1'b0},
      '{OP_DIHEDRAL, 32'sh1E_0000, 32'sd0, 18'sh1FFFF, 3'd3, 32'sh7FFF_FFFF, 0, 48'd0, 1'b0},
      '{OP_DIHEDRAL, 32'sh1E_0000, 32'sd0, 18'sh20000, 3'd2, 32'sh8000_0000, 0, 48'd0, 1'b0},
      '{OP_DIHEDRAL, 32'sh7FFF_FFFF, 32'sh8000_0000, 18'sh20000, 3'd7, 32'sh8000_0000,
        0, 48'd0, 1'b0},
      '{OP_DIHEDRAL, 32'sh2D_0000, 32'sd0, -18'sd65536, 3'd4, 32'sd0, 1, 48'd0, 1'b0},
      '{OP_IMPROPER, 32'shBE_0000, -32'shAA_0000, 18'sd0, 3'd0, 32'sh7FFF_FFFF,
        1, 48'd0, 1'b0},
      '{OP_IMPROPER, -32'shC8_0000, 32'sd0, 18'sd0, 3'd0, 32'sh1_0000, 0, 48'd0, 1'b0},
      '{OP_IMPROPER, 32'shB4_0000, 32'sd0, 18'sd0, 3'd0, 32'sh1_0000, 0, 48'd0, 1'b0},
      '{OP_IMPROPER, 32'sh7FFF_FFFF, 32'sh8000_0000, 18'sd0, 3'd0, 32'sh7FFF_FFFF,
        1, E_MAX, 1'b1},
      '{OP_IMPROPER, 32'sh7FFF_FFFF, 32'sh8000_0000, 18'sd0, 3'd0, 32'sh8000_0000,
        1, E_MIN, 1'b1}
   };

   initial begin
      int waited;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_BOND;
      req_measured_value = '0;
      req_ref_value = '0;
      req_phase_cos = '0;
      req_multiplicity = '0;
      req_force_const = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_term(directed[i]);
         idle_gap(1'b0);
      end

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         send_term(random_term());
         // back-to-back stretches between gappy ones
         idle_gap((i % 400) < 120);
         if (i == RANDOM_COUNT / 2) begin
            start <= 1'b0;
            while (pending_energy.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;

      waited = 0;
      while (pending_energy.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_energy.size() == 0)
         $display("bonded_term_energy regression: pass");
      else
         $display("bonded_term_energy regression: fail");
      $finish;
   end

endmodule

@@ bonded_term_energy.f @@
hw/rtl/bte_pkg.sv
hw/rtl/bte_angred.sv
hw/rtl/bte_front.sv
hw/rtl/bte_fifo.sv
hw/rtl/bte_cordic.sv
hw/rtl/bte_back.sv
hw/rtl/bonded_term_energy.sv
tb/testbench.sv
